/* hw/rtl/lcm3_pkg.sv */
// Shared constants and controller/datapath interface types for the three-operand LCM block.
`timescale 1ns / 1ps

package lcm3_pkg;

    localparam int OPERAND_BITS_DEF = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic mul;
        logic next_round;
        logic out_load;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic zero;
        logic gcd_done;
        logic div_last;
        logic round;
        logic out_busy;
    } t_status;

endpackage

/* hw/rtl/lcm3_ctrl.sv */
// Controller state machine that sequences the GCD, division and multiply steps.
`timescale 1ns / 1ps

module lcm3_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  lcm3_pkg::t_status i_status,
    output lcm3_pkg::t_cmd   o_cmd
);
    import lcm3_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_GCD    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.zero) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (i_status.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FINISH;
                if (!i_status.round) begin
                    n_state = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // The second round is set up in the same cycle as the first product is written back.
        if (r_state == ST_MUL && !i_status.round) begin
            o_cmd.next_round = 1'b1;
            n_state          = ST_GCD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/lcm3_dp.sv */
// Datapath: binary GCD, restoring divider, multiplier and output register.
`timescale 1ns / 1ps

module lcm3_dp #(
    parameter int OPERAND_BITS = lcm3_pkg::OPERAND_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [OPERAND_BITS-1:0] i_a,
    input  logic [OPERAND_BITS-1:0] i_b,
    input  logic [OPERAND_BITS-1:0] i_c,
    input  lcm3_pkg::t_cmd          i_cmd,
    output lcm3_pkg::t_status       o_status,
    input  logic                    i_m_axis_tready,
    output logic                    o_m_axis_tvalid,
    output logic [3*OPERAND_BITS-1:0] o_multiple,
    output logic                    o_error
);
    import lcm3_pkg::*;

    localparam int OB = OPERAND_BITS;
    localparam int LW = 3 * OB;
    localparam int XW = 2 * OB;
    localparam int CW = $clog2(OB);
    localparam int KW = $clog2(OB + 1);

    logic [LW-1:0] r_l;
    logic [OB-1:0] r_y;
    logic [OB-1:0] r_c;
    logic [XW-1:0] r_x;
    logic [XW-1:0] r_v;
    logic [KW-1:0] r_k;
    logic          r_round;
    logic          r_zero;
    logic [OB-1:0] r_q;
    logic [OB-1:0] r_rem;
    logic [OB-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic [LW-1:0] r_out_mult;
    logic          r_out_err;
    logic          r_out_valid;

    logic [XW-1:0] g_full;
    logic [OB:0]   div_trial;
    logic          div_fits;
    logic [OB:0]   div_diff;
    logic [LW-1:0] prod;
    logic          in_zero;

    assign in_zero   = (i_a == '0) || (i_b == '0) || (i_c == '0);
    assign g_full    = r_x << r_k;
    assign div_trial = {r_rem, r_q[OB-1]};
    assign div_fits  = (div_trial >= {1'b0, r_d});
    assign div_diff  = div_trial - {1'b0, r_d};
    assign prod      = r_l[XW-1:0] * r_q;

    assign o_status.zero     = r_zero;
    assign o_status.gcd_done = (r_x == r_v);
    assign o_status.div_last = (r_cnt == '0);
    assign o_status.round    = r_round;
    assign o_status.out_busy = r_out_valid && !i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_multiple      = r_out_mult;
    assign o_error         = r_out_err;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero  <= in_zero;
            r_round <= 1'b0;
            r_l     <= in_zero ? '0 : LW'(i_a);
            r_y     <= i_b;
            r_c     <= i_c;
            r_x     <= XW'(i_a);
            r_v     <= XW'(i_b);
            r_k     <= '0;
        end
        if (i_cmd.next_round) begin
            r_round <= 1'b1;
            r_y     <= r_c;
            r_x     <= prod[XW-1:0];
            r_v     <= XW'(r_c);
            r_k     <= '0;
        end
        // Binary GCD: strip common and single factors of two, then subtract odd values.
        if (i_cmd.gcd_step) begin
            priority if (!r_x[0] && !r_v[0]) begin
                r_x <= r_x >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_x > r_v) begin
                r_x <= (r_x - r_v) >> 1;
            end else begin
                r_v <= (r_v - r_x) >> 1;
            end
        end
        // The GCD divides the current operand, so it fits in one operand width.
        if (i_cmd.div_init) begin
            r_d   <= g_full[OB-1:0];
            r_q   <= r_y;
            r_rem <= '0;
            r_cnt <= CW'(OB - 1);
        end
        if (i_cmd.div_step) begin
            r_q   <= {r_q[OB-2:0], div_fits};
            r_rem <= div_fits ? div_diff[OB-1:0] : div_trial[OB-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.mul) begin
            r_l <= prod;
        end
        if (i_cmd.out_load) begin
            r_out_mult <= r_l;
            r_out_err  <= r_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

/* hw/rtl/lcm_of_three.sv */
// Sequence: a zero operand goes from acceptance through the check state to the finish
// state; otherwise the check state is followed by two rounds, each of binary GCD
// steps, one divider start, the divider steps and one multiply, and then the finish
// state. Throughput: one item at a time; the next item is taken once the result is
// in the output register. Reset (synchronous, active low) returns the controller to
// idle and empties the output register.
`timescale 1ns / 1ps

module lcm_of_three #(
    parameter int OPERAND_BITS = lcm3_pkg::OPERAND_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // first_operand, second_operand, third_operand, zero fill
    input  logic [((3*OPERAND_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // multiple, zero fill
    output logic [((3*OPERAND_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // zero_operand_error
    output logic o_m_axis_tuser
);
    import lcm3_pkg::*;

    localparam int OB = OPERAND_BITS;
    localparam int DW = ((3 * OB + 7) / 8) * 8;

    t_cmd            cmd;
    t_status         status;
    logic [3*OB-1:0] multiple;

    lcm3_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    lcm3_dp #(
        .OPERAND_BITS (OB)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_a             (i_s_axis_tdata[OB-1:0]),
        .i_b             (i_s_axis_tdata[2*OB-1:OB]),
        .i_c             (i_s_axis_tdata[3*OB-1:2*OB]),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_multiple      (multiple),
        .o_error         (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = DW'(multiple);

endmodule

/* test/lcm_of_three_tb.sv */
// Self-checking testbench for the three-operand least common multiple block.
`timescale 1ns / 1ps

module lcm_of_three_tb;

    localparam int OPERAND_BITS = lcm3_pkg::OPERAND_BITS_DEF;
    localparam int DATA_BITS    = ((3 * OPERAND_BITS + 7) / 8) * 8;
    localparam int MULT_BITS    = 3 * OPERAND_BITS;
    localparam int OPERAND_MAX  = (1 << OPERAND_BITS) - 1;
    localparam int RANDOM_ITEMS = 580;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 4_000_000;

    typedef struct packed {
        logic [MULT_BITS-1:0] multiple;
        logic                 zero_operand_error;
    } lcm_result_t;

    class lcm_scoreboard;
        lcm_result_t expected_q[$];
        int          failures;

        function new();
            failures = 0;
        endfunction

        function logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
            logic [63:0] rem;
            while (y != 0) begin
                rem = x % y;
                x   = y;
                y   = rem;
            end
            return x;
        endfunction

        function logic [63:0] lcm64(input logic [63:0] x, input logic [63:0] y);
            return (x / gcd64(x, y)) * y;
        endfunction

        function lcm_result_t predict_lcm(input logic [OPERAND_BITS-1:0] a,
                                          input logic [OPERAND_BITS-1:0] b,
                                          input logic [OPERAND_BITS-1:0] c);
            lcm_result_t res;
            logic [63:0] m;
            res = '0;
            if (a == 0 || b == 0 || c == 0) begin
                res.zero_operand_error = 1'b1;
            end else begin
                m = lcm64(lcm64(64'(a), 64'(b)), 64'(c));
                res.multiple = m[MULT_BITS-1:0];
            end
            return res;
        endfunction

        function void note_operands(input logic [OPERAND_BITS-1:0] a,
                                    input logic [OPERAND_BITS-1:0] b,
                                    input logic [OPERAND_BITS-1:0] c);
            expected_q.push_back(predict_lcm(a, b, c));
        endfunction

        function void check_result(input logic [MULT_BITS-1:0] multiple, input logic err);
            lcm_result_t exp_res;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected result multiple=%0d error=%0b", multiple, err);
                return;
            end
            exp_res = expected_q.pop_front();
            if (exp_res.multiple !== multiple || exp_res.zero_operand_error !== err) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: expected multiple=%0d error=%0b, got multiple=%0d error=%0b",
                             exp_res.multiple, exp_res.zero_operand_error, multiple, err);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    // first_operand, second_operand, third_operand, zero fill
    logic [DATA_BITS-1:0] i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    // multiple, zero fill
    logic [DATA_BITS-1:0] o_m_axis_tdata;
    // zero_operand_error
    logic                 o_m_axis_tuser;

    lcm_scoreboard sb = new();
    bit            calm;
    int            cycles;

    lcm_of_three #(
        .OPERAND_BITS(OPERAND_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none at all in calm stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 200);
    endfunction

    task automatic send_operands(input logic [OPERAND_BITS-1:0] a,
                                 input logic [OPERAND_BITS-1:0] b,
                                 input logic [OPERAND_BITS-1:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= DATA_BITS'({c, b, a});
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_operands(a, b, c);
    endtask

    task automatic send_random_item();
        int kind;
        int rot;
        int base;
        logic [OPERAND_BITS-1:0] ops[3];
        logic [OPERAND_BITS-1:0] tmp;
        kind = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++)
            ops[k] = OPERAND_BITS'($urandom_range(0, OPERAND_MAX));
        if (kind < 35) begin
            // full-range operands as drawn
        end else if (kind < 55) begin
            for (int k = 0; k < 3; k++)
                ops[k] = OPERAND_BITS'($urandom_range(1, 64));
        end else if (kind < 70) begin
            // A shared factor keeps the result well below the product.
            base = $urandom_range(1, 4095);
            for (int k = 0; k < 3; k++)
                ops[k] = OPERAND_BITS'(base * $urandom_range(1, 16));
        end else if (kind < 80) begin
            ops[0] = OPERAND_BITS'($urandom_range(1, 2047));
            ops[1] = OPERAND_BITS'(ops[0] * $urandom_range(1, 32));
        end else if (kind < 88) begin
            rot = $urandom_range(1, 7);
            for (int k = 0; k < 3; k++)
                if (rot[k])
                    ops[k] = '0;
        end else if (kind < 94) begin
            for (int k = 0; k < 3; k++)
                ops[k] = OPERAND_BITS'(OPERAND_MAX - $urandom_range(0, 255));
        end else begin
            for (int k = 0; k < 3; k++)
                ops[k] = OPERAND_BITS'(1 << $urandom_range(0, OPERAND_BITS - 1));
        end
        // Rotate so that the largest operand turns up in every position.
        rot = $urandom_range(0, 2);
        repeat (rot) begin
            tmp    = ops[0];
            ops[0] = ops[1];
            ops[1] = ops[2];
            ops[2] = tmp;
        end
        send_operands(ops[0], ops[1], ops[2]);
    endtask

    // Result side: checks each accepted item and stalls at random.
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata[MULT_BITS-1:0], o_m_axis_tuser);
            if (stall_left > 0)
                stall_left--;
            else if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            i_m_axis_tready <= (stall_left == 0);
        end
    end

    initial begin
        cycles = 0;
        calm   = 1'b0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_operands(16'd1, 16'd1, 16'd1);
        send_operands(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_operands(16'hFFFF, 16'hFFFE, 16'hFFFD);
        send_operands(16'd65521, 16'd65519, 16'd65497);
        send_operands(16'd0, 16'd5, 16'd7);
        send_operands(16'd5, 16'd0, 16'd7);
        send_operands(16'd5, 16'd7, 16'd0);
        send_operands(16'd0, 16'd0, 16'd0);
        send_operands(16'd0, 16'hFFFF, 16'hFFFF);
        send_operands(16'd1, 16'd1, 16'hFFFF);
        send_operands(16'hFFFF, 16'd1, 16'd1);
        send_operands(16'd4, 16'd8, 16'd16);
        send_operands(16'd16, 16'd8, 16'd4);
        send_operands(16'd6, 16'd10, 16'd15);
        send_operands(16'h8000, 16'h4000, 16'd1);
        send_operands(16'd12, 16'd12, 16'd12);
        send_operands(16'd2, 16'd3, 16'd5);
        send_operands(16'd7, 16'd14, 16'd3);
        send_operands(16'hFFFF, 16'd3, 16'd5);
        send_operands(16'd1, 16'hFFFF, 16'd2);
        send_operands(16'hAAAA, 16'h5555, 16'hFFFF);
        send_operands(16'h5555, 16'hAAAA, 16'd1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            send_random_item();
        end
        i_s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* lcm_of_three.f */
hw/rtl/lcm3_pkg.sv
hw/rtl/lcm3_ctrl.sv
hw/rtl/lcm3_dp.sv
hw/rtl/lcm_of_three.sv
test/lcm_of_three_tb.sv
